### rtl/core/lsdt_pkg.sv
// lsdt_pkg: shared constants and types for the lru stack-distance tracker
// used by lsdt_cell, lsdt_checker and lru_stack_distance_tracker_core; depends on nothing
package lsdt_pkg;

    // default geometry of the stack
    localparam int DEPTH_DEF    = 64;
    localparam int KEY_BITS_DEF = 64;

    // fixed widths of the item fields
    localparam int REQ_W = 64;
    localparam int OUT_W = 7;

    // per-cycle control broadcast to every cell of the chain
    typedef struct packed {
        logic capture;   // an item is accepted: compare the request against the held key
        logic update;    // shift phase: take the neighbour's entry unless a hit lies in front
    } t_cell_ctl;

endpackage

### rtl/core/lru_stack_distance_tracker_core.sv
// lru_stack_distance_tracker_core: top level, a chain of lsdt_cell positions with
// request capture, first-hit encoder and result register; depends on lsdt_pkg, lsdt_cell
//
// An item is taken when start is high and busy is low, and the block takes no new
// item while busy is high: at the accept edge every cell compares the request with
// its key at once, and in the following cycle (busy high) a hit flag ripples down the
// chain, each cell up to and including the hit takes its neighbour's entry, and the
// request enters at the front. The result is driven on the o_ ports for exactly one
// cycle, marked by o_valid, which is registered from the internal busy flag after the
// shift phase; it is not held, so the receiver must take it in that cycle and cannot
// stall the block. busy is also high while reset is asserted.
module lru_stack_distance_tracker_core #(
    parameter int DEPTH    = lsdt_pkg::DEPTH_DEF,
    parameter int KEY_BITS = lsdt_pkg::KEY_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [lsdt_pkg::REQ_W-1:0] i_request_key,
    output logic                              o_valid,
    output logic                              o_hit,
    output logic [lsdt_pkg::OUT_W-1:0]        o_hit_age,
    output logic [lsdt_pkg::OUT_W-1:0]        o_peak_age,
    output logic                              o_oldest_dropped,
    output logic [lsdt_pkg::OUT_W-1:0]        o_occupancy
);

    localparam int AW   = $clog2(DEPTH + 1);
    localparam int IDXW = $clog2(DEPTH);

    logic                r_busy;
    logic [KEY_BITS-1:0] r_req_key;
    logic [AW-1:0]       r_count;
    logic [AW-1:0]       r_peak;

    logic                accept;
    lsdt_pkg::t_cell_ctl cell_ctl;
    logic [KEY_BITS-1:0] req_key;

    logic [KEY_BITS-1:0] c_key   [DEPTH];
    logic                c_valid [DEPTH];
    logic [DEPTH-1:0]    c_match;
    logic [DEPTH:0]      seen;

    logic [IDXW-1:0]     hit_idx;
    logic                hit;
    logic                full;
    logic [AW-1:0]       age;
    logic [AW-1:0]       n_peak;
    logic [AW-1:0]       n_count;

    // handshake
    assign busy   = r_busy | !i_rst_n;
    assign accept = start && !busy;
    assign req_key = i_request_key[KEY_BITS-1:0];

    assign cell_ctl.capture = accept;
    assign cell_ctl.update  = r_busy;

    // request register for the shift phase
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_key <= req_key;
        end
    end

    // chain of cells, the front cell takes the request
    assign seen[0] = 1'b0;
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KEY_BITS-1:0] prev_key;
        logic                prev_valid;
        if (g == 0) begin : g_front
            assign prev_key   = r_req_key;
            assign prev_valid = 1'b1;
        end else begin : g_rest
            assign prev_key   = c_key[g-1];
            assign prev_valid = c_valid[g-1];
        end
        lsdt_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_req_key    (req_key),
            .i_prev_key   (prev_key),
            .i_prev_valid (prev_valid),
            .i_seen       (seen[g]),
            .o_key        (c_key[g]),
            .o_valid      (c_valid[g]),
            .o_match      (c_match[g]),
            .o_seen       (seen[g+1])
        );
    end

    // position of the first matching cell
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (c_match[i] && !seen[i]) begin
                hit_idx = hit_idx | IDXW'(i);
            end
        end
    end

    assign hit     = seen[DEPTH];
    assign full    = (r_count == AW'(DEPTH));
    assign age     = hit ? (AW'(hit_idx) + AW'(1)) : '0;
    assign n_peak  = (age > r_peak) ? age : r_peak;
    assign n_count = (hit || full) ? r_count : (r_count + AW'(1));

    // control state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
            r_peak  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_busy  <= accept;
            o_valid <= r_busy;
            if (r_busy) begin
                r_count <= n_count;
                r_peak  <= n_peak;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            o_hit            <= hit;
            o_hit_age        <= lsdt_pkg::OUT_W'(age);
            o_peak_age       <= lsdt_pkg::OUT_W'(n_peak);
            o_oldest_dropped <= !hit && full;
            o_occupancy      <= lsdt_pkg::OUT_W'(n_count);
        end
    end

endmodule

### rtl/core/lsdt_cell.sv
// lsdt_cell: one stack position holding a key, its valid bit and its match flag
// depends on lsdt_pkg (t_cell_ctl)
module lsdt_cell #(
    parameter int KEY_BITS = lsdt_pkg::KEY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lsdt_pkg::t_cell_ctl  i_ctl,
    input  logic [KEY_BITS-1:0]  i_req_key,
    input  logic [KEY_BITS-1:0]  i_prev_key,
    input  logic                 i_prev_valid,
    input  logic                 i_seen,
    output logic [KEY_BITS-1:0]  o_key,
    output logic                 o_valid,
    output logic                 o_match,
    output logic                 o_seen
);

    logic [KEY_BITS-1:0] r_key;
    logic                r_valid;
    logic                r_match;

    // stored key, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctl.update && !i_seen) begin
            r_key <= i_prev_key;
        end
    end

    // valid bit and match flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.capture) begin
                r_match <= r_valid && (r_key == i_req_key);
            end
            if (i_ctl.update && !i_seen) begin
                r_valid <= i_prev_valid;
            end
        end
    end

    // a hit at or in front of this cell stops the shift behind it
    assign o_seen  = i_seen | r_match;
    assign o_key   = r_key;
    assign o_valid = r_valid;
    assign o_match = r_match;

endmodule

### rtl/core/lsdt_checker.sv
// lsdt_checker: port-level assertions for lru_stack_distance_tracker_core
// depends on lsdt_pkg; bound to the top level below
module lsdt_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_valid,
    input logic                       o_hit,
    input logic [lsdt_pkg::OUT_W-1:0] o_hit_age,
    input logic                       o_oldest_dropped
);

    // an accepted item yields a result marked by o_valid after its shift phase
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result missing two cycles after accept");

    // the block is busy for the shift cycle after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // a result only appears as busy falls at the end of an item's shift phase
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy))
        else $error("result without an item in flight");

    // a dropped key only on a miss, and a miss carries no age
    a_drop_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_oldest_dropped || !o_hit)) |-> !o_hit && (o_hit_age == '0) ||
            (o_hit && !o_oldest_dropped))
        else $error("dropped flag or age inconsistent with miss");

endmodule

bind lru_stack_distance_tracker_core lsdt_checker u_lsdt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_hit            (o_hit),
    .o_hit_age        (o_hit_age),
    .o_oldest_dropped (o_oldest_dropped)
);
